// File: sv/lcc_pkg.sv
`default_nettype none

package lcc_pkg;

    localparam int MUL_W = 33;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               first_of_list;
    } lcc_in_t;

    typedef struct packed {
        logic [3:0]  cluster_index;
        logic        new_cluster;
        logic        overflow;
        logic [10:0] member_count;
    } lcc_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_NX,
        ST_MUL_NY,
        ST_MUL_RN,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_RN,
        ST_CMP,
        ST_UPDATE
    } lcc_state_t;

endpackage

`default_nettype wire

// File: sv/lcc_table.sv
`default_nettype none

module lcc_table #(
    parameter int DEPTH  = 16,
    parameter int IDX_W  = 4,
    parameter int DATA_W = 65
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/lcc_mul.sv
`default_nettype none

module lcc_mul
    import lcc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic signed [MUL_W-1:0]   op_a,
    input  wire logic signed [MUL_W-1:0]   op_b,
    output logic      signed [2*MUL_W-1:0] prod
);

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: sv/leader_centroid_clusterer_unit.sv
`default_nettype none

// Leader clustering of 2D Q8.8 points against per-cluster centroids. A point joins the
// lowest-index cluster whose centroid lies strictly inside the configured radius, tested exactly
// as (n*x-sx)^2+(n*y-sy)^2 < (r*n)^2 (overflow if that cluster is full), else opens a new cluster
// (overflow if the table is full); first_of_list empties the table first. One request yields one
// result. A request visits clusters in index order, up to those in use (at most MAX_CLUSTERS):
// each visit is one table read and six products through the single registered multiplier, then
// a compare. A list's first point, or a point arriving at an empty table, goes straight to the
// update. The final update also waits for as long as an earlier result is still held in the
// output register. The input is not ready while a point is in work; a finished result waits in
// the output register while the next request is taken. The table needs no clearing after reset.
module leader_centroid_clusterer_unit
    import lcc_pkg::*;
#(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_MEMBERS  = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire lcc_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output lcc_out_t         m_data,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam int D_W   = SUM_W + 1;
    localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int U_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int ENT_W = 2 * SUM_W + CNT_W;
    localparam logic [U_W-1:0]   USED_MAX = U_W'(MAX_CLUSTERS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_MEMBERS);
    localparam logic [63:0]      SQ_LIMIT = 64'h1_0000_0000;

    lcc_state_t state_reg, state_next;

    logic [15:0]             radius_reg;
    logic [U_W-1:0]          used_reg, used_next;
    logic [U_W-1:0]          iter_reg, iter_next;
    logic signed [15:0]      pos_x_reg, pos_x_next;
    logic signed [15:0]      pos_y_reg, pos_y_next;
    logic                    found_reg, found_next;
    logic signed [D_W-1:0]   dx_reg, dx_next;
    logic signed [D_W-1:0]   dy_reg, dy_next;
    logic [31:0]             rn_reg, rn_next;
    logic [63:0]             dx2_reg, dx2_next;
    logic [63:0]             dy2_reg, dy2_next;
    logic                    satx_reg, satx_next;
    logic                    saty_reg, saty_next;
    lcc_out_t                out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    tbl_rd_en;
    logic [IDX_W-1:0]        tbl_rd_addr;
    logic [ENT_W-1:0]        tbl_rd_data;
    logic                    tbl_we;
    logic [IDX_W-1:0]        tbl_wr_addr;
    logic [ENT_W-1:0]        tbl_wr_data;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_prod;

    logic signed [SUM_W-1:0] ent_sx, ent_sy, prod_low;
    logic [CNT_W-1:0]        ent_n;
    logic [D_W-1:0]          absx, absy;
    logic [63:0]             absx64, absy64;
    logic [64:0]             dist2;
    logic                    match;
    logic                    s_accept;
    logic                    out_free;
    logic [U_W-1:0]          used_start;
    logic [U_W-1:0]          iter_inc;

    lcc_table #(
        .DEPTH  (MAX_CLUSTERS),
        .IDX_W  (IDX_W),
        .DATA_W (ENT_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    lcc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;
    assign out_free   = !out_valid_reg || m_ready;
    assign used_start = s_data.first_of_list ? '0 : used_reg;
    assign iter_inc   = iter_reg + U_W'(1);

    assign ent_sx   = $signed(tbl_rd_data[ENT_W-1 -: SUM_W]);
    assign ent_sy   = $signed(tbl_rd_data[CNT_W +: SUM_W]);
    assign ent_n    = tbl_rd_data[CNT_W-1:0];
    assign prod_low = $signed(mul_prod[SUM_W-1:0]);

    assign absx   = dx_reg[D_W-1] ? D_W'(-dx_reg) : D_W'(dx_reg);
    assign absy   = dy_reg[D_W-1] ? D_W'(-dy_reg) : D_W'(dy_reg);
    assign absx64 = 64'(absx);
    assign absy64 = 64'(absy);
    assign dist2  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign match  = !satx_reg && !saty_reg && (dist2 < {1'b0, mul_prod[63:0]});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (used_start == '0) ? ST_UPDATE : ST_READ;
                end
            end
            ST_READ:   state_next = ST_MUL_NX;
            ST_MUL_NX: state_next = ST_MUL_NY;
            ST_MUL_NY: state_next = ST_MUL_RN;
            ST_MUL_RN: state_next = ST_SQ_DX;
            ST_SQ_DX:  state_next = ST_SQ_DY;
            ST_SQ_DY:  state_next = ST_SQ_RN;
            ST_SQ_RN:  state_next = ST_CMP;
            ST_CMP: begin
                state_next = (match || iter_inc == used_reg) ? ST_UPDATE : ST_READ;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        used_next      = used_reg;
        iter_next      = iter_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        found_next     = found_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        rn_next        = rn_reg;
        dx2_next       = dx2_reg;
        dy2_next       = dy2_reg;
        satx_next      = satx_reg;
        saty_next      = saty_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        tbl_rd_en      = 1'b0;
        tbl_rd_addr    = iter_reg[IDX_W-1:0];
        tbl_we         = 1'b0;
        tbl_wr_addr    = iter_reg[IDX_W-1:0];
        tbl_wr_data    = tbl_rd_data;
        mul_a          = '0;
        mul_b          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pos_x_next = s_data.pos_x;
                    pos_y_next = s_data.pos_y;
                    used_next  = used_start;
                    iter_next  = '0;
                    found_next = 1'b0;
                end
            end
            ST_READ: begin
                tbl_rd_en = 1'b1;
            end
            ST_MUL_NX: begin
                mul_a = MUL_W'($signed({1'b0, ent_n}));
                mul_b = MUL_W'(pos_x_reg);
            end
            ST_MUL_NY: begin
                mul_a   = MUL_W'($signed({1'b0, ent_n}));
                mul_b   = MUL_W'(pos_y_reg);
                dx_next = D_W'(prod_low) - D_W'(ent_sx);
            end
            ST_MUL_RN: begin
                mul_a   = MUL_W'($signed({1'b0, radius_reg}));
                mul_b   = MUL_W'($signed({1'b0, ent_n}));
                dy_next = D_W'(prod_low) - D_W'(ent_sy);
            end
            ST_SQ_DX: begin
                mul_a   = $signed({1'b0, absx64[31:0]});
                mul_b   = $signed({1'b0, absx64[31:0]});
                rn_next = mul_prod[31:0];
            end
            ST_SQ_DY: begin
                mul_a     = $signed({1'b0, absy64[31:0]});
                mul_b     = $signed({1'b0, absy64[31:0]});
                dx2_next  = mul_prod[63:0];
                satx_next = (absx64 >= SQ_LIMIT);
            end
            ST_SQ_RN: begin
                mul_a     = $signed({1'b0, rn_reg});
                mul_b     = $signed({1'b0, rn_reg});
                dy2_next  = mul_prod[63:0];
                saty_next = (absy64 >= SQ_LIMIT);
            end
            ST_CMP: begin
                if (match) begin
                    found_next = 1'b1;
                end else begin
                    iter_next = iter_inc;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next.new_cluster = 1'b0;
                    out_next.overflow    = 1'b0;
                    if (found_reg) begin
                        out_next.cluster_index = 4'(iter_reg[IDX_W-1:0]);
                        if (ent_n >= CNT_MAX) begin
                            out_next.overflow     = 1'b1;
                            out_next.member_count = 11'(ent_n);
                        end else begin
                            tbl_we      = 1'b1;
                            tbl_wr_addr = iter_reg[IDX_W-1:0];
                            tbl_wr_data = {ent_sx + SUM_W'(pos_x_reg),
                                           ent_sy + SUM_W'(pos_y_reg),
                                           ent_n + CNT_W'(1)};
                            out_next.member_count = 11'(ent_n + CNT_W'(1));
                        end
                    end else if (used_reg >= USED_MAX) begin
                        out_next.cluster_index = '0;
                        out_next.overflow      = 1'b1;
                        out_next.member_count  = '0;
                    end else begin
                        tbl_we      = 1'b1;
                        tbl_wr_addr = used_reg[IDX_W-1:0];
                        tbl_wr_data = {SUM_W'(pos_x_reg), SUM_W'(pos_y_reg), CNT_W'(1)};
                        used_next   = used_reg + U_W'(1);
                        out_next.cluster_index = 4'(used_reg[IDX_W-1:0]);
                        out_next.new_cluster   = 1'b1;
                        out_next.member_count  = 11'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            radius_reg    <= 16'd256;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                radius_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg  <= iter_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        found_reg <= found_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        rn_reg    <= rn_next;
        dx2_reg   <= dx2_next;
        dy2_reg   <= dy2_next;
        satx_reg  <= satx_next;
        saty_reg  <= saty_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

// File: sv/lcc_checker.sv
`default_nettype none

module lcc_checker
    import lcc_pkg::*;
#(
    parameter int MAX_MEMBERS = 1024
) (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire lcc_in_t  s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire lcc_out_t m_data
);

    localparam logic [10:0] FULL_COUNT = 11'(MAX_MEMBERS);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a new cluster holds exactly this point
    a_new_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.new_cluster |-> !m_data.overflow && m_data.member_count == 11'd1)
        else $error("new cluster with bad count or overflow");

    // dropped point reports a full cluster or the table-full marker
    a_drop_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |->
            (m_data.cluster_index == 4'd0 && m_data.member_count == 11'd0)
            || m_data.member_count == FULL_COUNT)
        else $error("overflow result malformed");

    // first point of a list always opens cluster zero
    a_first_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.first_of_list ##1 !m_valid ##1 m_valid |->
            m_data.new_cluster && m_data.cluster_index == 4'd0)
        else $error("first point of list did not open cluster zero");

endmodule

bind leader_centroid_clusterer_unit lcc_checker #(
    .MAX_MEMBERS (MAX_MEMBERS)
) u_lcc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: tb/leader_centroid_clusterer_unit_test.sv
`default_nettype none

module leader_centroid_clusterer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lcc_pkg::*;

    localparam int TABLE_SIZE   = 16;
    localparam int MEMBER_LIMIT = 1024;
    localparam int RESET_RADIUS = 256;
    localparam int SETTLE_CYCLES = 4;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    lcc_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    lcc_out_t    m_data;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // predicted cluster table
    longint      model_sum_x [TABLE_SIZE];
    longint      model_sum_y [TABLE_SIZE];
    int          model_members [TABLE_SIZE];
    int          model_used   = 0;
    int          model_radius = RESET_RADIUS;

    lcc_out_t    pending_results [$];
    int          mismatch_count = 0;
    bit          no_idle = 1'b0;

    leader_centroid_clusterer_unit #(
        .MAX_CLUSTERS(TABLE_SIZE),
        .MAX_MEMBERS (MEMBER_LIMIT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic lcc_out_t classify_point(input lcc_in_t p);
        longint   x;
        longint   y;
        longint   n;
        longint   dx;
        longint   dy;
        longint   lim;
        int       hit;
        lcc_out_t r;
        x = longint'($signed(p.pos_x));
        y = longint'($signed(p.pos_y));
        hit = -1;
        r = '0;
        if (p.first_of_list) begin
            model_used = 0;
        end
        for (int i = 0; i < model_used; i++) begin
            if (hit < 0) begin
                n   = longint'(model_members[i]);
                dx  = n * x - model_sum_x[i];
                dy  = n * y - model_sum_y[i];
                lim = longint'(model_radius) * n;
                if (dx * dx + dy * dy < lim * lim) begin
                    hit = i;
                end
            end
        end
        if (hit >= 0) begin
            r.cluster_index = 4'(hit);
            if (model_members[hit] >= MEMBER_LIMIT) begin
                r.overflow = 1'b1;
            end else begin
                model_sum_x[hit]   += x;
                model_sum_y[hit]   += y;
                model_members[hit] += 1;
            end
            r.member_count = 11'(model_members[hit]);
        end else if (model_used >= TABLE_SIZE) begin
            r.overflow = 1'b1;
        end else begin
            model_sum_x[model_used]   = x;
            model_sum_y[model_used]   = y;
            model_members[model_used] = 1;
            r.cluster_index = 4'(model_used);
            r.new_cluster   = 1'b1;
            r.member_count  = 11'd1;
            model_used += 1;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) begin
            return 16'sd32767;
        end else if (v < -32768) begin
            return -16'sd32768;
        end
        return 16'(v);
    endfunction

    function automatic lcc_in_t make_point(input int x, input int y, input bit first);
        lcc_in_t p;
        p.pos_x = clamp16(x);
        p.pos_y = clamp16(y);
        p.first_of_list = first;
        return p;
    endfunction

    function automatic lcc_in_t random_point(input bit first);
        lcc_in_t p;
        p.pos_x = 16'($urandom);
        p.pos_y = 16'($urandom);
        p.first_of_list = first;
        return p;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_point(input lcc_in_t p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.insert(pending_results.size(), classify_point(p));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() > 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_radius(input int r);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= 16'(r);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        model_radius = r;
    endtask

    // reset radius, exact boundary, coordinate extremes, list restart
    task automatic test_directed();
        send_point(make_point(0, 0, 1'b1));
        send_point(make_point(256, 0, 1'b0));
        send_point(make_point(0, 255, 1'b0));
        send_point(make_point(0, -256, 1'b0));
        send_point(make_point(-32768, -32768, 1'b1));
        send_point(make_point(32767, 32767, 1'b0));
        send_point(make_point(32767, -32768, 1'b0));
        send_point(make_point(-32768, 32767, 1'b0));
        send_point(make_point(-1, -1, 1'b0));
        send_point(make_point(-32768, -32700, 1'b0));
        send_point(make_point(0, 0, 1'b1));
        send_point(make_point(-255, 0, 1'b0));
    endtask

    // zero radius opens a cluster per point until the table is full, then radius 65535 on a new list
    task automatic test_table_full();
        write_radius(0);
        send_point(make_point(100, 100, 1'b1));
        send_point(make_point(100, 100, 1'b0));
        for (int i = 0; i < 16; i++) begin
            send_point(random_point(1'b0));
        end
        write_radius(65535);
        send_point(make_point(-32768, -32768, 1'b1));
        send_point(make_point(32767, 32767, 1'b0));
    endtask

    // one cluster filled past its member limit
    task automatic test_member_limit();
        write_radius(65535);
        send_point(make_point(0, 0, 1'b1));
        for (int i = 0; i < MEMBER_LIMIT + 2; i++) begin
            send_point(make_point($urandom_range(0, 4095) - 2048,
                                  $urandom_range(0, 4095) - 2048, 1'b0));
        end
        send_point(make_point(32767, 32767, 1'b0));
        send_point(make_point(-32768, -32768, 1'b0));
    endtask

    // sender holds off until the block has drained
    task automatic test_drain_pause();
        write_radius(512);
        for (int i = 0; i < 10; i++) begin
            send_point(random_point(i == 0));
        end
        wait_idle();
        for (int i = 0; i < 10; i++) begin
            send_point(random_point(1'b0));
        end
    endtask

    task automatic test_random_lists(input int r, input int count, input bit quiet);
        int      cx [20];
        int      cy [20];
        int      ncent;
        int      len;
        int      left;
        int      sel;
        int      c;
        int      spread;
        lcc_in_t p;
        write_radius(r);
        no_idle = quiet;
        left = count;
        while (left > 0) begin
            ncent = $urandom_range(1, 20);
            for (int k = 0; k < ncent; k++) begin
                cx[k] = $urandom_range(0, 65535) - 32768;
                cy[k] = $urandom_range(0, 65535) - 32768;
            end
            len = $urandom_range(1, 40);
            spread = (r == 0) ? 4 : $urandom_range((r + 3) / 4, r);
            for (int j = 0; j < len && left > 0; j++) begin
                sel = $urandom_range(0, 9);
                if (sel < 8) begin
                    c = $urandom_range(0, ncent - 1);
                    p = make_point(cx[c] + $urandom_range(0, 2 * spread) - spread,
                                   cy[c] + $urandom_range(0, 2 * spread) - spread, j == 0);
                end else begin
                    p = random_point(j == 0 || (sel == 9 && $urandom_range(0, 3) == 0));
                end
                send_point(p);
                left--;
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random stall before each result, none while no_idle is set
    initial begin
        wait (aresetn);
        @(negedge aclk);
        forever begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: index %0d count %0d",
                       m_data.cluster_index, m_data.member_count);
                mismatch_count++;
            end else begin
                lcc_out_t want;
                want = pending_results.pop_front();
                if (m_data.cluster_index !== want.cluster_index) begin
                    $error("cluster_index: expected %0d, actual %0d",
                           want.cluster_index, m_data.cluster_index);
                    mismatch_count++;
                end
                if (m_data.new_cluster !== want.new_cluster) begin
                    $error("new_cluster: expected %0d, actual %0d",
                           want.new_cluster, m_data.new_cluster);
                    mismatch_count++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, actual %0d",
                           want.overflow, m_data.overflow);
                    mismatch_count++;
                end
                if (m_data.member_count !== want.member_count) begin
                    $error("member_count: expected %0d, actual %0d",
                           want.member_count, m_data.member_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("leader_centroid_clusterer_unit_test: errors");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_table_full();
        test_member_limit();
        test_drain_pause();
        test_random_lists(RESET_RADIUS, 120, 1'b0);
        test_random_lists(1, 60, 1'b0);
        test_random_lists(0, 50, 1'b0);
        test_random_lists(65535, 100, 1'b0);
        test_random_lists($urandom_range(2, 4096), 100, 1'b1);
        test_random_lists($urandom_range(4096, 65534), 70, 1'b0);
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("leader_centroid_clusterer_unit_test: clean");
        end else begin
            $display("leader_centroid_clusterer_unit_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/lcc_pkg.sv
sv/lcc_table.sv
sv/lcc_mul.sv
sv/leader_centroid_clusterer_unit.sv
sv/lcc_checker.sv
tb/leader_centroid_clusterer_unit_test.sv
